// File: design/ccds_pkg.sv
// Package for the cone cost disk stamp block: grid geometry, command codes,
// register indexes and the front-to-back job record. No dependencies.
package ccds_pkg;

    localparam int GRID_W      = 256;
    localparam int GRID_H      = 256;
    localparam int MAX_RADIUS  = 15;
    localparam int LETHAL_COST = 254;
    localparam int COST_CAP    = 252;

    localparam int COL_W  = $clog2(GRID_W);
    localparam int ROW_W  = $clog2(GRID_H);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int MAPW_W = 9;
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W  = RAD_W + 2;
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_STAMP = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_CPM      = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_RSQ      = 3'd4,
        REG_INV_R    = 3'd5,
        REG_MAP_W    = 3'd6,
        REG_MAP_H    = 3'd7
    } t_reg;

    // Classified job handed from front to back.
    typedef struct packed {
        t_cmd             op;
        logic             off_map;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             in_map;
    } t_job;

endpackage

// File: design/ccds_if.sv
// Valid/ready channel interfaces for the cone cost disk stamp block.
// No dependencies.
interface ccds_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] cone_x;
    logic signed [31:0] cone_y;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    modport source (output valid, cmd, cone_x, cone_y, cell_col, cell_row, input ready);
    modport sink   (input valid, cmd, cone_x, cone_y, cell_col, cell_row, output ready);
endinterface

interface ccds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cost;
    logic       status;
    modport source (output valid, cost, status, input ready);
    modport sink   (input valid, cost, status, output ready);
endinterface

interface ccds_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ccds_front.sv
// Front end: accepts items and maps a cone to its cell through difference,
// multiply and bound-check states. Depends on ccds_pkg.
module ccds_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ccds_in_if.sink              in_ch,
    input  logic signed [31:0]   i_origin_x,
    input  logic signed [31:0]   i_origin_y,
    input  logic [15:0]          i_cpm,
    input  logic [8:0]           i_used_w,
    input  logic [8:0]           i_used_h,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output ccds_pkg::t_job       o_job
);
    import ccds_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIFF, S_MUL, S_CHECK, S_OUT} t_state;

    t_state             r_state;
    t_job               r_job;
    logic signed [31:0] r_cx, r_cy;
    logic signed [32:0] r_dx, r_dy;
    logic [48:0]        r_px, r_py;

    logic [24:0] w_cx, w_cy;
    logic        w_offx, w_offy;

    assign in_ch.ready = (r_state == S_IDLE);
    assign o_job_valid = (r_state == S_OUT);
    assign o_job       = r_job;

    assign w_cx   = r_px[48:24];
    assign w_cy   = r_py[48:24];
    assign w_offx = r_dx[32] || (w_cx >= {16'd0, i_used_w});
    assign w_offy = r_dy[32] || (w_cy >= {16'd0, i_used_h});

    // Stamps: difference, multiply, bound check, hand over; others: hand over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_job.op  <= t_cmd'(in_ch.cmd);
                        r_job.off_map <= 1'b0;
                        r_job.col <= in_ch.cell_col[COL_W-1:0];
                        r_job.row <= in_ch.cell_row[ROW_W-1:0];
                        r_job.in_map <= ({1'b0, in_ch.cell_col} < i_used_w) &&
                                        ({1'b0, in_ch.cell_row} < i_used_h);
                        r_cx <= in_ch.cone_x;
                        r_cy <= in_ch.cone_y;
                        r_state <= (t_cmd'(in_ch.cmd) == CMD_STAMP) ? S_DIFF : S_OUT;
                    end
                end
                S_DIFF: begin
                    r_dx <= 33'(r_cx) - 33'(i_origin_x);
                    r_dy <= 33'(r_cy) - 33'(i_origin_y);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_px <= 49'(r_dx[31:0]) * 49'(i_cpm);
                    r_py <= 49'(r_dy[31:0]) * 49'(i_cpm);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_job.off_map <= w_offx || w_offy;
                    r_job.col <= w_cx[COL_W-1:0];
                    r_job.row <= w_cy[ROW_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_job_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/ccds_queue.sv
// Short job queue between front and back ends. Depends on ccds_pkg.
module ccds_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  ccds_pkg::t_job i_wr_job,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output ccds_pkg::t_job o_rd_job
);
    import ccds_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_wr_ready = (r_cnt < (PW+1)'(Q_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_job   = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_wr_job;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end
endmodule

// File: design/ccds_back.sv
// Back end: owns the cost grid; runs stamps, reads and clears.
// Depends on ccds_pkg.
module ccds_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  ccds_pkg::t_job i_job,
    input  logic [3:0]     i_radius,
    input  logic [15:0]    i_rsq,
    input  logic [15:0]    i_inv_r,
    input  logic [8:0]     i_used_w,
    input  logic [8:0]     i_used_h,
    output logic           o_busy,
    ccds_out_if.source     out_ch
);
    import ccds_pkg::*;

    typedef enum logic [3:0] {
        S_WIPE, S_IDLE, S_CELL, S_SQRT, S_MUL, S_COST, S_RD, S_WR, S_READ, S_READ2, S_RESP
    } t_state;

    t_state              r_state;
    logic [7:0]          r_mem [GRID_W*GRID_H];
    logic [7:0]          r_rdata;
    logic [ADDR_W-1:0]   r_wipe;
    logic [RAD_W-1:0]    r_r;
    logic signed [OFS_W-1:0] r_dx, r_dy;
    logic [COL_W-1:0]    r_mx;
    logic [ROW_W-1:0]    r_my;
    logic [ADDR_W-1:0]   r_addr;
    logic [8:0]          r_d2;
    logic [16:0]         r_rem;
    logic [12:0]         r_root;
    logic [3:0]          r_step;
    logic [28:0]         r_ratio;
    logic [7:0]          r_cost;
    logic [7:0]          r_out_cost;
    logic                r_out_status;
    logic                r_out_valid;

    logic signed [COL_W+1:0] w_nx;
    logic signed [ROW_W+1:0] w_ny;
    logic [8:0]          w_d2;
    logic                w_incl, w_last_dy, w_last_dx;
    logic [24:0]         w_rad;
    logic [4:0]          w_sh;
    logic [1:0]          w_pair;
    logic [16:0]         w_acc;
    logic [16:0]         w_trial;
    logic [8:0]          w_raw;

    assign o_job_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_busy      = (r_state != S_IDLE) || r_out_valid;
    assign out_ch.valid  = r_out_valid;
    assign out_ch.cost   = r_out_cost;
    assign out_ch.status = r_out_status;

    // Current window cell and its inclusion test.
    assign w_nx = (COL_W+2)'(signed'({1'b0, r_mx})) + (COL_W+2)'(r_dx);
    assign w_ny = (ROW_W+2)'(signed'({1'b0, r_my})) + (ROW_W+2)'(r_dy);
    assign w_d2 = 9'(r_dx * r_dx) + 9'(r_dy * r_dy);
    assign w_incl = !w_nx[COL_W+1] && !w_ny[ROW_W+1] &&
                    (w_nx < (COL_W+2)'(signed'({1'b0, i_used_w}))) &&
                    (w_ny < (ROW_W+2)'(signed'({1'b0, i_used_h}))) &&
                    ({w_d2, 8'd0} <= 17'(i_rsq));
    assign w_last_dy = (r_dy == OFS_W'(r_r));
    assign w_last_dx = (r_dx == OFS_W'(r_r));

    // Root step: bring down the next bit pair, trial = (root << 2) | 1.
    assign w_rad   = {r_d2, 16'd0};
    assign w_sh    = 5'd24 - {r_step, 1'b0};
    assign w_pair  = 2'(w_rad >> w_sh);
    assign w_acc   = {r_rem[14:0], w_pair};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_raw   = 9'((34'(LETHAL_COST) * (34'(1 << 24) - 34'(r_ratio))) >> 24);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RD:    r_rdata <= r_mem[r_addr];
            S_READ:  r_rdata <= r_mem[r_addr];
            S_WIPE:  r_mem[r_wipe] <= 8'd0;
            S_WR:    if (r_cost > r_rdata) r_mem[r_addr] <= r_cost;
            default: ;
        endcase
    end

    // Job sequencer: grid wipe, reads; for stamps cell walk, root search, cost, read-modify-write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
            r_wipe <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_WIPE: begin
                    r_wipe <= r_wipe + 1'b1;
                    if (&r_wipe) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_job_valid && !r_out_valid) begin
                        r_out_cost <= 8'd0;
                        r_out_status <= 1'b0;
                        case (i_job.op)
                            CMD_STAMP: begin
                                if (i_job.off_map) begin
                                    r_out_status <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_r  <= (i_radius > 4'(MAX_RADIUS)) ?
                                            RAD_W'(MAX_RADIUS) : RAD_W'(i_radius);
                                    r_dx <= -OFS_W'(signed'({1'b0, i_radius}));
                                    r_dy <= -OFS_W'(signed'({1'b0, i_radius}));
                                    r_mx <= i_job.col;
                                    r_my <= i_job.row;
                                    r_state <= S_CELL;
                                end
                            end
                            CMD_READ: begin
                                r_addr <= {i_job.row, i_job.col};
                                if (i_job.in_map) r_state <= S_READ;
                                else r_out_valid <= 1'b1;
                            end
                            CMD_CLEAR: begin
                                r_wipe <= '0;
                                r_out_valid <= 1'b1;
                                r_state <= S_WIPE;
                            end
                            default: r_out_valid <= 1'b1;
                        endcase
                    end
                end
                S_CELL: begin
                    r_addr <= {w_ny[ROW_W-1:0], w_nx[COL_W-1:0]};
                    r_d2 <= w_d2;
                    r_rem <= '0;
                    r_root <= '0;
                    r_step <= 4'd0;
                    if (w_incl) r_state <= (w_d2 == 9'd0) ? S_COST : S_SQRT;
                    else if (w_last_dy && w_last_dx) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_last_dy) begin
                        r_dy <= -OFS_W'(signed'({1'b0, r_r}));
                        r_dx <= r_dx + 1'b1;
                    end else r_dy <= r_dy + 1'b1;
                    r_cost <= 8'(LETHAL_COST);
                end
                S_SQRT: begin
                    // Digit-by-digit root of d2<<16: 13 result bits, one per step.
                    if (w_acc >= w_trial) begin
                        r_rem <= w_acc - w_trial;
                        r_root <= {r_root[11:0], 1'b1};
                    end else begin
                        r_rem <= w_acc;
                        r_root <= {r_root[11:0], 1'b0};
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd12) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_ratio <= 29'(r_root) * 29'(i_inv_r);
                    r_state <= S_COST;
                end
                S_COST: begin
                    if (r_d2 != 9'd0) begin
                        if (|r_ratio[28:24]) r_cost <= 8'd0;
                        else if (w_raw > 9'(COST_CAP)) r_cost <= 8'(COST_CAP);
                        else r_cost <= w_raw[7:0];
                    end
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    if (w_last_dy && w_last_dx) begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (w_last_dy) begin
                            r_dy <= -OFS_W'(signed'({1'b0, r_r}));
                            r_dx <= r_dx + 1'b1;
                        end else r_dy <= r_dy + 1'b1;
                        r_state <= S_CELL;
                    end
                end
                S_READ: r_state <= S_READ2;
                S_READ2: begin
                    r_out_cost <= r_rdata;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/cone_cost_disk_stamp.sv
// Top level of the cone cost disk stamp block: registers, front, queue, back.
// Depends on ccds_pkg, ccds_if, ccds_front, ccds_queue, ccds_back.
//
// A 256x256 8-bit cost grid. After reset, and after every clear, a clearing
// pass zeroes the grid one cell a cycle; no stamp or read is served then.
// A stamp walks up to (2r+1)^2 window cells, one cell at a time, as the
// grid has a single port and the root unit is serial; each included cell
// goes through a 13-step square root, cost and a grid read-modify-write,
// and each skipped cell is passed over.
module cone_cost_disk_stamp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccds_in_if.sink     in_ch,
    ccds_out_if.source  out_ch,
    ccds_cfg_if.sink    cfg_ch
);
    import ccds_pkg::*;

    logic signed [31:0] r_origin_x, r_origin_y;
    logic [15:0]        r_cpm, r_rsq, r_inv_r;
    logic [3:0]         r_radius;
    logic [8:0]         r_map_w, r_map_h;
    logic [8:0]         w_used_w, w_used_h;
    logic               w_fv, w_fr, w_bv, w_br, w_busy;
    t_job               w_fjob, w_bjob;

    assign cfg_ch.ready = 1'b1;
    assign w_used_w = (r_map_w > 9'(GRID_W)) ? 9'(GRID_W) : r_map_w;
    assign w_used_h = (r_map_h > 9'(GRID_H)) ? 9'(GRID_H) : r_map_h;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_cpm <= 16'd5120;
            r_radius <= 4'd7;
            r_rsq <= 16'd10485;
            r_inv_r <= 16'd10240;
            r_map_w <= 9'd256;
            r_map_h <= 9'd256;
        end else if (cfg_ch.valid) begin
            case (t_reg'(cfg_ch.index))
                REG_ORIGIN_X: r_origin_x <= cfg_ch.data;
                REG_ORIGIN_Y: r_origin_y <= cfg_ch.data;
                REG_CPM:      r_cpm <= cfg_ch.data[15:0];
                REG_RADIUS:   r_radius <= cfg_ch.data[3:0];
                REG_RSQ:      r_rsq <= cfg_ch.data[15:0];
                REG_INV_R:    r_inv_r <= cfg_ch.data[15:0];
                REG_MAP_W:    r_map_w <= cfg_ch.data[8:0];
                REG_MAP_H:    r_map_h <= cfg_ch.data[8:0];
                default: ;
            endcase
        end
    end

    ccds_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .i_origin_x(r_origin_x), .i_origin_y(r_origin_y), .i_cpm(r_cpm),
        .i_used_w(w_used_w), .i_used_h(w_used_h),
        .o_job_valid(w_fv), .i_job_ready(w_fr), .o_job(w_fjob)
    );

    ccds_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(w_fv), .o_wr_ready(w_fr), .i_wr_job(w_fjob),
        .o_rd_valid(w_bv), .i_rd_ready(w_br), .o_rd_job(w_bjob)
    );

    ccds_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_bv), .o_job_ready(w_br), .i_job(w_bjob),
        .i_radius(r_radius), .i_rsq(r_rsq), .i_inv_r(r_inv_r),
        .i_used_w(w_used_w), .i_used_h(w_used_h),
        .o_busy(w_busy), .out_ch
    );

    // A result held back by the sink stays valid with its cost unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cost))
        else $error("result changed while stalled");

    // An off-map result never carries a cost.
    a_off_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.status |-> out_ch.cost == 8'd0)
        else $error("off-map result with nonzero cost");

    // A job never moves into the back end while a result is pending.
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bv && w_br |-> !out_ch.valid)
        else $error("job taken while result pending");

    // Nothing is read or stamped with the back end already busy on a job.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_br |-> !w_busy || out_ch.valid)
        else $error("back end ready while busy");
endmodule
